>>> rtl/sha1mh_pkg.sv
package sha1mh_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] block_t;
  typedef logic [4:0][31:0] chain_t;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctrl_t;

  localparam chain_t CHAIN_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam word_t ROUND_K0 = 32'h5A827999;
  localparam word_t ROUND_K1 = 32'h6ED9EBA1;
  localparam word_t ROUND_K2 = 32'h8F1BBCDC;
  localparam word_t ROUND_K3 = 32'hCA62C1D6;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd4;

endpackage

>>> rtl/sha1mh_core.sv
module sha1mh_core (
  input  logic                   clk,
  input  logic                   rst,
  input  sha1mh_pkg::core_ctrl_t ctrl,
  input  sha1mh_pkg::block_t     block,
  output logic                   done,
  output sha1mh_pkg::chain_t     chain
);

  typedef enum logic [2:0] {
    CORE_IDLE  = 3'b001,
    CORE_ROUND = 3'b010,
    CORE_ADD   = 3'b100
  } core_state_t;

  core_state_t        state;
  logic [6:0]         round;
  sha1mh_pkg::block_t w;
  sha1mh_pkg::word_t  a, b, c, d, e;
  sha1mh_pkg::word_t  f, k, t, mix;

  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = sha1mh_pkg::ROUND_K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1mh_pkg::ROUND_K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1mh_pkg::ROUND_K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1mh_pkg::ROUND_K3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w[0];
    mix = w[13] ^ w[8] ^ w[2] ^ w[0];
  end

  assign done = (state == CORE_ADD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
      round <= '0;
      chain <= sha1mh_pkg::CHAIN_IV;
    end else begin
      case (state)
        CORE_IDLE: begin
          if (ctrl.init) begin
            chain <= sha1mh_pkg::CHAIN_IV;
          end
          if (ctrl.start) begin
            round <= '0;
            state <= CORE_ROUND;
          end
        end
        CORE_ROUND: begin
          round <= round + 7'd1;
          if (round == sha1mh_pkg::LAST_ROUND) begin
            state <= CORE_ADD;
          end
        end
        CORE_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          state <= CORE_IDLE;
        end
        default: begin
          state <= CORE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == CORE_IDLE && ctrl.start) begin
      w <= block;
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (state == CORE_ROUND) begin
      w <= {{mix[30:0], mix[31]}, w[15:1]};
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

endmodule

>>> rtl/sha1_message_hasher.sv
// SHA-1 message hasher.
// The msg channel carries one item per message byte: byte_value with
// byte_present set, and end_of_message set on the item that closes the
// message. An item with end_of_message and byte_present clear closes the
// message without adding a byte, so it also hashes the empty message.
// A byte that completes a 64-byte block holds msg_stall high while the
// 80-round compression unit runs one round per cycle; other bytes, but a
// closing one, are taken without a stall.
// After a closing item the block pads byte by byte, compresses the last
// block (a second one when the length does not fit), then offers the five
// digest words on the digest channel, most significant first, with
// last_word on the fifth. The wait for the first digest word is set by the
// padding bytes and by whether one or two compressions run.
// A stalled digest item holds its value. No new message byte is taken until
// the fifth word has gone. Reset returns the chaining words to the initial
// values and clears the byte and length counts.
module sha1_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [7:0]  byte_value,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_BLOCK = 5'b00010,
    S_PAD   = 5'b00100,
    S_FINAL = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t                 state;
  logic [5:0]             pos;
  logic [63:0]            bit_count;
  logic                   after_close;
  logic                   pad_first;
  logic                   core_start;
  logic                   core_start_next;
  logic [2:0]             out_idx;
  logic                   put_en;
  logic [7:0]             put_byte;
  logic                   core_done;
  sha1mh_pkg::block_t     block_words;
  sha1mh_pkg::chain_t     chain;
  sha1mh_pkg::core_ctrl_t core_ctrl;

  assign msg_stall = (state != S_IDLE);
  assign digest_valid = (state == S_OUT);
  assign digest_word = chain[out_idx];
  assign word_index = out_idx;
  assign last_word = (out_idx == sha1mh_pkg::LAST_WORD);

  assign core_ctrl.start = core_start;
  assign core_ctrl.init = (state == S_OUT) && !digest_stall &&
                          (out_idx == sha1mh_pkg::LAST_WORD);

  assign core_start_next = (put_en && pos == sha1mh_pkg::LAST_POS) ||
                           (state == S_PAD && !put_en);

  always_comb begin
    put_en = 1'b0;
    put_byte = '0;
    if (state == S_IDLE && msg_valid && byte_present) begin
      put_en = 1'b1;
      put_byte = byte_value;
    end else if (state == S_PAD && (pad_first || pos != sha1mh_pkg::LEN_POS)) begin
      put_en = 1'b1;
      put_byte = pad_first ? sha1mh_pkg::PAD_MARK : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      if (pos[1:0] == 2'd0) begin
        block_words[pos[5:2]] <= {put_byte, 24'h000000};
      end else begin
        block_words[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= put_byte;
      end
    end else if (state == S_PAD) begin
      block_words[14] <= bit_count[63:32];
      block_words[15] <= bit_count[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos <= '0;
      bit_count <= '0;
      after_close <= 1'b0;
      pad_first <= 1'b0;
      core_start <= 1'b0;
      out_idx <= '0;
    end else begin
      core_start <= core_start_next;
      if (put_en) begin
        pos <= pos + 6'd1;
      end
      case (state)
        S_IDLE: begin
          if (msg_valid) begin
            if (byte_present) begin
              bit_count <= bit_count + 64'd8;
            end
            if (end_of_message) begin
              pad_first <= 1'b1;
            end
            if (byte_present && pos == sha1mh_pkg::LAST_POS) begin
              after_close <= end_of_message;
              state <= S_BLOCK;
            end else if (end_of_message) begin
              after_close <= 1'b1;
              state <= S_PAD;
            end
          end
        end
        S_BLOCK: begin
          if (core_done) begin
            state <= after_close ? S_PAD : S_IDLE;
          end
        end
        S_PAD: begin
          if (put_en) begin
            pad_first <= 1'b0;
            if (pos == sha1mh_pkg::LAST_POS) begin
              state <= S_BLOCK;
            end
          end else begin
            pos <= '0;
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (core_done) begin
            out_idx <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!digest_stall) begin
            if (out_idx == sha1mh_pkg::LAST_WORD) begin
              out_idx <= '0;
              bit_count <= '0;
              after_close <= 1'b0;
              state <= S_IDLE;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  sha1mh_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (core_ctrl),
    .block (block_words),
    .done  (core_done),
    .chain (chain)
  );

endmodule
